// File: rtl/core/asymmetric_button_debouncer_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the debouncer RTL
// Concurrent checks that compile away when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef ASYMMETRIC_BUTTON_DEBOUNCER_DEFINES_SVH
`define ASYMMETRIC_BUTTON_DEBOUNCER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ABD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ABD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ABD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)

`define ABD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: rtl/core/abd_pkg.sv
// ----------------------------------------------------------------------------
// abd_pkg
// Shared constants and types of the asymmetric button debouncer.
// ----------------------------------------------------------------------------
package abd_pkg;

    localparam int FIELD_W = 4;   // width of the per-slot bit fields
    localparam int TIME_W  = 32;  // millisecond timestamp width
    localparam int DEB_W   = 16;  // debounce time register width

    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd50;

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_DEBOUNCE_MS = 1'b0,
        REG_UNUSED      = 1'b1
    } abd_reg_t;

    typedef struct packed {
        logic [FIELD_W-1:0] debounced;
        logic [FIELD_W-1:0] edges;
    } abd_result_t;

endpackage

// File: rtl/core/asymmetric_button_debouncer.sv
// ----------------------------------------------------------------------------
// asymmetric_button_debouncer
// Per-slot timed debouncer: presses wait out debounce_ms, releases pass at once.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, pressed_bits, now_ms  | request in
//  out     | out_valid, out_ready, debounced_bits,     | request out
//          | edge_bits                                 |
//  cfg     | psel, penable, pwrite, paddr, pwdata,     | APB slave
//          | prdata, pready                            |
//
//  One request per cycle while in_ready is high. The slot update (edge
//  compare, 32-bit elapsed subtract, compare to debounce_ms) is done at
//  accept. The result is written at the accepting edge to the output
//  register (offered from the next cycle on) or, if full, to the skid.
//  A two-deep output (result register plus skid) keeps in_ready high while
//  one result waits; in_ready drops only when both are full.
//  Reset: raw/debounced levels clear, slots settled, change times zero,
//  debounce_ms = 50.
//
`include "asymmetric_button_debouncer_defines.svh"

module asymmetric_button_debouncer
    import abd_pkg::*;
#(
    parameter int SLOTS = 4
)
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    output logic                in_ready,
    input  logic [FIELD_W-1:0]  pressed_bits,
    input  logic [TIME_W-1:0]   now_ms,

    output logic                out_valid,
    input  logic                out_ready,
    output logic [FIELD_W-1:0]  debounced_bits,
    output logic [FIELD_W-1:0]  edge_bits,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    // Slots above the field width never see a press, so they hold no state.
    localparam int LANES = (SLOTS > FIELD_W) ? FIELD_W : SLOTS;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [DEB_W-1:0] debounce_reg;
    abd_reg_t         reg_sel;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign reg_sel   = abd_reg_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
        end
        else if (cfg_write && (reg_sel == REG_DEBOUNCE_MS))
        begin
            debounce_reg <= pwdata[DEB_W-1:0];
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_DEBOUNCE_MS: prdata = {{(32-DEB_W){1'b0}}, debounce_reg};
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Slot state
    // ------------------------------------------------------------------
    logic [LANES-1:0]  raw_prev_reg,  raw_prev_next;
    logic [LANES-1:0]  deb_level_reg, deb_level_next;
    logic [LANES-1:0]  settled_reg,   settled_next;
    logic [TIME_W-1:0] ct_reg  [LANES];
    logic [TIME_W-1:0] ct_next [LANES];
    logic [TIME_W-1:0] elapsed [LANES];
    logic [LANES-1:0]  lane_edge;
    logic              in_fire;
    abd_result_t       result;

    assign in_fire = in_valid && in_ready;

    always_comb
    begin
        raw_prev_next  = raw_prev_reg;
        deb_level_next = deb_level_reg;
        settled_next   = settled_reg;
        result         = '0;
        for (int i = 0; i < LANES; i++)
        begin
            ct_next[i]   = ct_reg[i];
            elapsed[i]   = now_ms - ct_reg[i];
            lane_edge[i] = pressed_bits[i] != raw_prev_reg[i];

            if (lane_edge[i])
            begin
                ct_next[i]      = now_ms;
                settled_next[i] = 1'b0;
            end

            if (!settled_next[i])
            begin
                if (pressed_bits[i])
                begin
                    // on an edge the slot timer restarts, so the press is never taken then
                    if (!lane_edge[i] && !deb_level_reg[i] &&
                        (elapsed[i] > {{(TIME_W-DEB_W){1'b0}}, debounce_reg}))
                    begin
                        settled_next[i]   = 1'b1;
                        deb_level_next[i] = 1'b1;
                    end
                end
                else
                begin
                    // release is taken immediately
                    settled_next[i]   = 1'b1;
                    deb_level_next[i] = 1'b0;
                end
            end

            raw_prev_next[i]    = pressed_bits[i];
            result.debounced[i] = deb_level_next[i];
            result.edges[i]     = lane_edge[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_prev_reg  <= '0;
            deb_level_reg <= '0;
            settled_reg   <= '1;
            for (int i = 0; i < LANES; i++)
            begin
                ct_reg[i] <= '0;
            end
        end
        else if (in_fire)
        begin
            raw_prev_reg  <= raw_prev_next;
            deb_level_reg <= deb_level_next;
            settled_reg   <= settled_next;
            for (int i = 0; i < LANES; i++)
            begin
                ct_reg[i] <= ct_next[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register with skid stage
    // ------------------------------------------------------------------
    logic        out_valid_reg, out_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    abd_result_t out_data_reg, out_data_next;
    abd_result_t skid_data_reg, skid_data_next;
    logic        out_take;

    assign in_ready = !skid_valid_reg;
    assign out_take = out_valid_reg && out_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;

        if (out_take)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end

        if (in_fire)
        begin
            if (!out_valid_next)
            begin
                out_data_next  = result;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = result;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid      = out_valid_reg;
    assign debounced_bits = out_data_reg.debounced;
    assign edge_bits      = out_data_reg.edges;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `ABD_ASSERT_IMPLY(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg, "skid full with output empty")
    `ABD_ASSERT_NEXT(a_stall_to_skid, clk, rst_n, in_fire && out_valid_reg && !out_ready, skid_valid_reg, "stalled request not parked in skid")
    `ABD_ASSERT_IMPLY(a_deb_needs_raw, clk, rst_n, 1'b1, (deb_level_reg & ~raw_prev_reg) == '0, "debounced press on released raw input")
    `ABD_ASSERT_NEXT(a_edge_stamps_time, clk, rst_n, in_fire && lane_edge[0], ct_reg[0] == $past(now_ms), "edge did not restart slot timer")

endmodule

// File: bench/asymmetric_button_debouncer_test.sv
// ----------------------------------------------------------------------------
// asymmetric_button_debouncer_test
// Self-checking bench for the timed button debouncer. A queue of samples
// feeds a random-idling driver. Each accepted sample runs through a local
// copy of the slot logic, and a monitor with random back-pressure compares
// each result field by field. The debounce register is reprogrammed between
// phases: 0, 65535, 1, a random value and 50.
// ----------------------------------------------------------------------------
module asymmetric_button_debouncer_test;
    import abd_pkg::*;

    // register addresses: index in paddr[2], byte lanes below it
    localparam logic [2:0] ADDR_DEBOUNCE = {REG_DEBOUNCE_MS, 2'b00};
    localparam logic [2:0] ADDR_SPARE    = {REG_UNUSED, 2'b00};

    localparam int PERIOD      = 12;
    localparam int PHASE_ITEMS = 300;     // random samples per setting
    localparam int HOLD_CYCLES = 150;     // long receiver stall
    localparam int QUIET_LO    = 800;     // no-idle window, in sent requests
    localparam int QUIET_HI    = 1000;

    typedef struct packed {
        logic [FIELD_W-1:0] bits;
        logic [TIME_W-1:0]  stamp;
    } sample_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // all block inputs start at a known value
    logic                in_valid     = 1'b0;
    logic [FIELD_W-1:0]  pressed_bits = '0;
    logic [TIME_W-1:0]   now_ms       = '0;
    logic                out_ready    = 1'b0;
    logic                psel         = 1'b0;
    logic                penable      = 1'b0;
    logic                pwrite       = 1'b0;
    logic [2:0]          paddr        = '0;
    logic [31:0]         pwdata       = '0;

    logic                in_ready;
    logic                out_valid;
    logic [FIELD_W-1:0]  debounced_bits;
    logic [FIELD_W-1:0]  edge_bits;
    logic [31:0]         prdata;
    logic                pready;

    // local copy of the slot state and the debounce register
    logic [FIELD_W-1:0]  raw_prev  = '0;
    logic [FIELD_W-1:0]  deb_level = '0;
    logic [FIELD_W-1:0]  settled   = '1;
    logic [TIME_W-1:0]   t_change [FIELD_W] = '{default: '0};
    logic [DEB_W-1:0]    deb_cfg   = DEBOUNCE_RESET;

    sample_t     pending [$];     // samples waiting for the driver
    abd_result_t results_due [$]; // predicted results, oldest first

    int sent     = 0;
    int checked  = 0;
    int failures = 0;

    int  hold_left = 0;
    bit  hold_done = 1'b0;

    logic [TIME_W-1:0] stamp_ms = '0;   // running timestamp for stimulus
    logic [FIELD_W-1:0] level   = '0;   // running raw button levels

    asymmetric_button_debouncer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .pressed_bits   (pressed_bits),
        .now_ms         (now_ms),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .debounced_bits (debounced_bits),
        .edge_bits      (edge_bits),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always
    begin
        #(PERIOD / 2) clk = 1'b1;
        #(PERIOD / 2) clk = 1'b0;
    end

    // One sample through the slot logic: an edge restarts the slot timer,
    // a release is taken at once, a press only after more than deb_cfg ms.
    // Elapsed time wraps at 32 bits, so a backwards timestamp reads as long.
    function automatic abd_result_t debounce_sample(input logic [FIELD_W-1:0] raw,
                                                    input logic [TIME_W-1:0] now);
        abd_result_t       r;
        logic [TIME_W-1:0] elapsed;
        r = '0;
        for (int s = 0; s < FIELD_W; s++)
        begin
            if (raw[s] != raw_prev[s])
            begin
                t_change[s] = now;
                settled[s]  = 1'b0;
                r.edges[s]  = 1'b1;
            end
            if (!settled[s])
            begin
                if (raw[s])
                begin
                    elapsed = now - t_change[s];
                    if (elapsed > TIME_W'(deb_cfg) && !deb_level[s])
                    begin
                        settled[s]   = 1'b1;
                        deb_level[s] = 1'b1;
                    end
                end
                else
                begin
                    settled[s]   = 1'b1;
                    deb_level[s] = 1'b0;
                end
            end
            raw_prev[s] = raw[s];
        end
        r.debounced = deb_level;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents queued samples, idles at random outside the quiet
    // window, holds the request steady while the block stalls it.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        sample_t nxt;
        bit      quiet;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            quiet = (sent >= QUIET_LO && sent < QUIET_HI);
            if (in_valid && in_ready)
            begin
                results_due.push_back(debounce_sample(pressed_bits, now_ms));
                sent++;
            end
            // a stalled request stays as it is
            if (!(in_valid && !in_ready))
            begin
                if (pending.size() > 0 && (quiet || $urandom_range(0, 99) >= 32))
                begin
                    nxt = pending.pop_front();
                    in_valid     <= 1'b1;
                    pressed_bits <= nxt.bits;
                    now_ms       <= nxt.stamp;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each accepted result against the oldest prediction
    // and drives out_ready, with one long stall to fill the block up.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        abd_result_t want;
        bit          quiet;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            quiet = (sent >= QUIET_LO && sent < QUIET_HI);
            if (out_valid && out_ready)
            begin
                if (results_due.size() == 0)
                begin
                    $error("result with nothing expected: debounced_bits %h edge_bits %h",
                           debounced_bits, edge_bits);
                    failures++;
                end
                else
                begin
                    want = results_due.pop_front();
                    if (debounced_bits !== want.debounced)
                    begin
                        $error("debounced_bits: expected %h, got %h",
                               want.debounced, debounced_bits);
                        failures++;
                    end
                    if (edge_bits !== want.edges)
                    begin
                        $error("edge_bits: expected %h, got %h", want.edges, edge_bits);
                        failures++;
                    end
                end
                checked++;
            end

            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!hold_done && checked >= 300)
            begin
                // sender keeps going; result reg and skid fill, in_ready drops
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= quiet || ($urandom_range(0, 99) >= 32);
            end
        end
    end

    // bus cycle: setup, then access until pready
    task automatic apb_xfer(input bit wr, input logic [2:0] addr,
                            input logic [31:0] data, output logic [31:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // write a register, mirror it locally, read the debounce time back
    task automatic reg_set(input logic [2:0] addr, input logic [31:0] data);
        logic [31:0] rd;
        apb_xfer(1'b1, addr, data, rd);
        if (addr == ADDR_DEBOUNCE)
            deb_cfg = data[DEB_W-1:0];    // upper bits dropped
        apb_xfer(1'b0, ADDR_DEBOUNCE, '0, rd);
        if (rd[DEB_W-1:0] !== deb_cfg)
        begin
            $error("debounce_ms readback: expected %h, got %h", deb_cfg, rd[DEB_W-1:0]);
            failures++;
        end
    endtask

    // wait until the block has drained and every predicted result is checked
    task automatic wait_drained();
        while (pending.size() != 0 || in_valid || results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic queue_sample(input logic [FIELD_W-1:0] bits, input logic [TIME_W-1:0] t);
        pending.push_back('{bits: bits, stamp: t});
    endtask

    // Random samples under the current setting. Mostly slow button
    // activity with time steps scaled to debounce_ms, plus press-and-hold
    // bursts that land on the threshold, backwards time, and noise.
    task automatic queue_random(input int n);
        int d;
        int mode;
        int k;
        d = deb_cfg;
        k = 0;
        while (k < n)
        begin
            mode = $urandom_range(0, 99);
            if (mode < 65)
            begin
                level    = level ^ (4'($urandom_range(0, 15)) & 4'($urandom_range(0, 15)));
                stamp_ms = stamp_ms + 32'($urandom_range(0, d / 3 + 2));
                queue_sample(level, stamp_ms);
                k++;
            end
            else if (mode < 80)
            begin
                // new levels, then exactly d ms later, then d+1 ms later
                level = 4'($urandom_range(0, 15));
                queue_sample(level, stamp_ms);
                queue_sample(level, stamp_ms + 32'(d));
                stamp_ms = stamp_ms + 32'(d) + 32'd1;
                queue_sample(level, stamp_ms);
                k += 3;
            end
            else if (mode < 90)
            begin
                // timestamp runs backwards
                level    = level ^ 4'($urandom_range(0, 15));
                stamp_ms = stamp_ms - 32'($urandom_range(0, d + 10));
                queue_sample(level, stamp_ms);
                k++;
            end
            else
            begin
                level    = 4'($urandom_range(0, 15));
                stamp_ms = $urandom();
                queue_sample(level, stamp_ms);
                k++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus: reset, directed samples, then one random phase per
    // debounce setting, reprogramming only while the block is idle.
    // ------------------------------------------------------------------
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting, 50 ms
        queue_sample(4'h0, 32'd0);
        queue_sample(4'hF, 32'd100);          // all edges, nothing accepted
        queue_sample(4'hF, 32'd150);          // exactly 50 ms: still waiting
        queue_sample(4'hF, 32'd151);          // 51 ms: press accepted
        queue_sample(4'h0, 32'd152);          // release taken at once
        queue_sample(4'h5, 32'd200);
        queue_sample(4'h5, 32'd100);          // time went backwards: accepted
        queue_sample(4'hA, 32'hFFFF_FFF0);
        queue_sample(4'hA, 32'h0000_0030);    // wrap: 64 ms elapsed
        queue_sample(4'hF, 32'hFFFF_FFFF);
        queue_sample(4'hF, 32'hFFFF_FFFF);    // same ms: not accepted
        queue_sample(4'h0, 32'h8000_0000);
        wait_drained();

        // zero debounce: press still needs one ms
        reg_set(ADDR_DEBOUNCE, 32'h0000_0000);
        queue_sample(4'h0, 32'd1000);
        queue_sample(4'h3, 32'd1000);
        queue_sample(4'h3, 32'd1001);
        queue_sample(4'h1, 32'd1001);
        queue_sample(4'h9, 32'd1002);
        queue_sample(4'h9, 32'd1003);
        stamp_ms = 32'd1003;
        level    = 4'h9;
        queue_random(PHASE_ITEMS);
        wait_drained();

        // maximum, with junk in the upper bits that must be dropped
        reg_set(ADDR_DEBOUNCE, 32'hABCD_FFFF);
        // unused index: write ignored, readback stays 65535
        reg_set(ADDR_SPARE, 32'h0000_0007);
        queue_random(PHASE_ITEMS);
        wait_drained();

        reg_set(ADDR_DEBOUNCE, 32'd1);
        queue_random(PHASE_ITEMS);
        wait_drained();

        reg_set(ADDR_DEBOUNCE, 32'($urandom_range(2, 1000)) | (32'($urandom()) << 16));
        queue_random(PHASE_ITEMS);
        wait_drained();

        reg_set(ADDR_DEBOUNCE, 32'd50);
        queue_random(PHASE_ITEMS);
        wait_drained();

        $display("%0d samples sent, %0d results checked", sent, checked);
        $display("debounce times 0, 65535, 1, random and 50; one long output stall");
        if (failures == 0 && results_due.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #(PERIOD * 400000);
        $display("TB_ERROR");
        $finish;
    end

endmodule
